/* rtl/core/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg
// Types, operation and status codes shared by the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_RESET   = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_EXPIRE  = 3'd4;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_INACTIVE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EXPIRED  = 3'd3;
    localparam logic [2:0] ST_NONE_DUE = 3'd4;

    localparam int          MAX_OUT      = 16;
    localparam logic [31:0] WINDOW_RESET = 32'd3600000;
    localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  timer_id;
        logic [31:0] interval;
        logic        cyclic;
        logic        rebase_now;
        logic [47:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  timer_id_res;
        logic [47:0] next_wait;
        logic        earliest_changed;
        logic        last;
    } res_t;

    typedef struct packed {
        cmd_t cmd;
        logic id_ok;
    } front_item_t;

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? TIME_MAX : s[47:0];
    endfunction

endpackage

/* rtl/core/dtt_front.sv */
// ----------------------------------------------------------------------------
// dtt_front
// Two-entry command queue; checks the addressed slot against the table size.
// ----------------------------------------------------------------------------
module dtt_front #(
    parameter int SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  dtt_pkg::cmd_t       cmd,
    output logic                q_valid,
    output dtt_pkg::front_item_t q_item,
    input  logic                q_pop
);
    import dtt_pkg::*;

    front_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;
    front_item_t fi;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        fi.cmd   = cmd;
        fi.id_ok = ({5'd0, cmd.timer_id} < 9'(SLOTS));
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= fi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("front queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |=> (cnt_reg <= 2'd1)) else $error("front queue jumped");
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !q_pop) |=> full) else $error("front queue lost an entry");
`endif

endmodule

/* rtl/core/dtt_back.sv */
// ----------------------------------------------------------------------------
// dtt_back
// Sequencer over the timer memories: scans slots one per cycle, buffers the
// results of one command and streams them through an output register.
// ----------------------------------------------------------------------------
module dtt_back #(
    parameter int SLOTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  dtt_pkg::front_item_t q_item,
    output logic                 q_pop,
    input  logic [31:0]          window,
    output logic                 empty,
    input  logic                 pop,
    output dtt_pkg::res_t        res
);
    import dtt_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_RD      = 4'd3;
    localparam logic [3:0] S_EVAL    = 4'd4;
    localparam logic [3:0] S_ARM     = 4'd5;
    localparam logic [3:0] S_REARM   = 4'd6;
    localparam logic [3:0] S_WAITEND = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;

    localparam logic [1:0] M_FREE  = 2'd0;
    localparam logic [1:0] M_FIRST = 2'd1;
    localparam logic [1:0] M_PICK  = 2'd2;
    localparam logic [1:0] M_WAIT  = 2'd3;

    // timer memories
    logic [47:0] dl_mem  [SLOTS];
    logic [31:0] per_mem [SLOTS];
    logic        rep_mem [SLOTS];
    logic [47:0] dl_q;
    logic [31:0] per_q;
    logic        rep_q;
    logic [SW-1:0] rd_addr, wa;
    logic        we_dl, we_per, we_rep;
    logic [47:0] wdl;

    // control
    logic [3:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    front_item_t   item_reg, item_next;
    logic [SLOTS-1:0] active_reg, active_next, picked_reg, picked_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          pv_reg, pv_next;
    logic [SW-1:0] pidx_reg, pidx_next;
    logic          got_reg, got_next, first_reg, first_next, any_reg, any_next;
    logic          roll_reg, roll_next, best_rep_reg, best_rep_next;
    logic [SW-1:0] best_reg, best_next, cand_idx_reg, cand_idx_next;
    logic [47:0]   best_dl_reg, best_dl_next, cand_dl_reg, cand_dl_next;
    logic [31:0]   best_per_reg, best_per_next, arm_add_reg, arm_add_next;
    logic [47:0]   start_reg, start_next, last_seen_reg, last_seen_next;
    logic [47:0]   w_reg, w_next;
    logic [4:0]    npick_reg, npick_next;

    // result buffer
    logic [2:0] rb_st [MAX_OUT];
    logic [3:0] rb_id [MAX_OUT];
    logic       rb_ec [MAX_OUT];
    logic [4:0] res_cnt_reg, res_cnt_next;
    logic [3:0] emit_reg, emit_next;
    logic       rec_en;
    logic [2:0] rec_st;
    logic [3:0] rec_id;
    logic       rec_ec;

    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;

    logic [8:0]    id9;
    logic [SW-1:0] id_slot;
    logic [8:0]    cand9, best9;
    logic          act_j, scan_end, pick_c;
    logic [47:0]   now;

    assign id9     = {5'd0, item_reg.cmd.timer_id};
    assign id_slot = id9[SW-1:0];
    assign cand9   = 9'(cand_idx_reg);
    assign best9   = 9'(best_reg);
    assign now     = item_reg.cmd.now_ms;
    assign act_j   = active_reg[pidx_reg];
    assign scan_end = (scan_cnt_reg == CW'(SLOTS)) && !pv_reg;
    assign pick_c  = act_j && !picked_reg[pidx_reg] && (roll_reg || dl_q <= now);

    assign empty = !out_valid_reg;
    assign res   = out_reg;

    always_ff @(posedge clk)
    begin
        dl_q  <= dl_mem[rd_addr];
        per_q <= per_mem[rd_addr];
        rep_q <= rep_mem[rd_addr];
        if (we_dl)
        begin
            dl_mem[wa] <= wdl;
        end
        if (we_per)
        begin
            per_mem[wa] <= item_reg.cmd.interval;
        end
        if (we_rep)
        begin
            rep_mem[wa] <= item_reg.cmd.cyclic;
        end
        if (rec_en)
        begin
            rb_st[res_cnt_reg[3:0]] <= rec_st;
            rb_id[res_cnt_reg[3:0]] <= rec_id;
            rb_ec[res_cnt_reg[3:0]] <= rec_ec;
        end
        out_reg  <= out_next;
        item_reg <= item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        item_next      = item_reg;
        active_next    = active_reg;
        picked_next    = picked_reg;
        scan_cnt_next  = scan_cnt_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        got_next       = got_reg;
        first_next     = first_reg;
        any_next       = any_reg;
        roll_next      = roll_reg;
        best_next      = best_reg;
        best_dl_next   = best_dl_reg;
        best_per_next  = best_per_reg;
        best_rep_next  = best_rep_reg;
        cand_idx_next  = cand_idx_reg;
        cand_dl_next   = cand_dl_reg;
        arm_add_next   = arm_add_reg;
        start_next     = start_reg;
        last_seen_next = last_seen_reg;
        w_next         = w_reg;
        npick_next     = npick_reg;
        res_cnt_next   = res_cnt_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop   = 1'b0;
        rd_addr = id_slot;
        wa      = cand_idx_reg;
        we_dl   = 1'b0;
        we_per  = 1'b0;
        we_rep  = 1'b0;
        wdl     = sat_add(start_reg, arm_add_reg);
        rec_en  = 1'b0;
        rec_st  = ST_DONE;
        rec_id  = item_reg.cmd.timer_id;
        rec_ec  = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    item_next    = q_item;
                    res_cnt_next = 5'd0;
                    state_next   = S_DEC;
                end
            end
            S_DEC:
            begin
                mode_next     = M_WAIT;
                state_next    = S_SCAN;
                cand_idx_next = id_slot;
                case (item_reg.cmd.operation)
                    OP_ADD:
                    begin
                        mode_next = M_FREE;
                    end
                    OP_CANCEL:
                    begin
                        rec_en = 1'b1;
                        if (item_reg.id_ok && active_reg[id_slot])
                        begin
                            active_next[id_slot] = 1'b0;
                        end
                        else
                        begin
                            rec_st = ST_INACTIVE;
                        end
                    end
                    OP_RESET:
                    begin
                        if (item_reg.id_ok)
                        begin
                            state_next = S_RD;
                        end
                        else
                        begin
                            rec_en = 1'b1;
                            rec_st = ST_INACTIVE;
                        end
                    end
                    OP_RESTART:
                    begin
                        if (item_reg.id_ok && active_reg[id_slot])
                        begin
                            state_next = S_RD;
                        end
                        else
                        begin
                            rec_en = 1'b1;
                            rec_st = ST_INACTIVE;
                        end
                    end
                    OP_EXPIRE:
                    begin
                        mode_next   = M_PICK;
                        roll_next   = (last_seen_reg >= {16'd0, window}) &&
                                      (now < last_seen_reg - {16'd0, window});
                        picked_next = '0;
                        npick_next  = 5'd0;
                        any_next    = 1'b0;
                    end
                    default:
                    begin
                        rec_en = 1'b1;
                        rec_st = ST_INACTIVE;
                        rec_id = 4'd0;
                    end
                endcase
                scan_cnt_next = '0;
                pv_next       = 1'b0;
                got_next      = 1'b0;
                first_next    = 1'b1;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg < CW'(SLOTS))
                begin
                    rd_addr       = scan_cnt_reg[SW-1:0];
                    pv_next       = 1'b1;
                    pidx_next     = scan_cnt_reg[SW-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg)
                begin
                    case (mode_reg)
                        M_FREE:
                        begin
                            if (!act_j && !got_reg)
                            begin
                                got_next  = 1'b1;
                                best_next = pidx_reg;
                            end
                        end
                        M_FIRST:
                        begin
                            if (pidx_reg != cand_idx_reg && act_j &&
                                (dl_q < cand_dl_reg ||
                                 (dl_q == cand_dl_reg && pidx_reg < cand_idx_reg)))
                            begin
                                first_next = 1'b0;
                            end
                        end
                        M_PICK:
                        begin
                            if (act_j)
                            begin
                                any_next = 1'b1;
                            end
                            // ascending scan: strict less keeps the lower slot on ties
                            if (pick_c && (!got_reg || dl_q < best_dl_reg))
                            begin
                                got_next      = 1'b1;
                                best_next     = pidx_reg;
                                best_dl_next  = dl_q;
                                best_per_next = per_q;
                                best_rep_next = rep_q;
                            end
                        end
                        default:
                        begin
                            if (act_j && (!got_reg || dl_q < best_dl_reg))
                            begin
                                got_next     = 1'b1;
                                best_dl_next = dl_q;
                            end
                        end
                    endcase
                end
                else if (scan_end)
                begin
                    scan_cnt_next = '0;
                    pv_next       = 1'b0;
                    got_next      = 1'b0;
                    first_next    = 1'b1;
                    mode_next     = M_WAIT;
                    case (mode_reg)
                        M_FREE:
                        begin
                            if (got_reg)
                            begin
                                cand_idx_next = best_reg;
                                start_next    = now;
                                arm_add_next  = item_reg.cmd.interval;
                                state_next    = S_ARM;
                            end
                            else
                            begin
                                rec_en = 1'b1;
                                rec_st = ST_FULL;
                                rec_id = 4'd0;
                            end
                        end
                        M_FIRST:
                        begin
                            rec_en = 1'b1;
                            rec_id = cand9[3:0];
                            rec_ec = first_reg;
                        end
                        M_PICK:
                        begin
                            if (got_reg)
                            begin
                                rec_en = 1'b1;
                                rec_st = ST_EXPIRED;
                                rec_id = best9[3:0];
                                picked_next[best_reg] = 1'b1;
                                state_next = S_REARM;
                            end
                            else
                            begin
                                if (npick_reg == 5'd0)
                                begin
                                    rec_en = 1'b1;
                                    rec_st = ST_NONE_DUE;
                                    rec_id = 4'd0;
                                end
                                if (any_reg)
                                begin
                                    last_seen_next = now;
                                end
                            end
                        end
                        default:
                        begin
                            got_next   = got_reg;
                            state_next = S_WAITEND;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                rd_addr    = id_slot;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_ARM;
                start_next = now;
                if (item_reg.cmd.operation == OP_RESTART)
                begin
                    arm_add_next = per_q;
                end
                else
                begin
                    arm_add_next = item_reg.cmd.interval;
                    if (!item_reg.cmd.rebase_now)
                    begin
                        start_next = (dl_q >= {16'd0, per_q}) ?
                                     dl_q - {16'd0, per_q} : 48'd0;
                    end
                    if ((!item_reg.cmd.rebase_now && item_reg.cmd.interval == per_q) ||
                        !active_reg[id_slot])
                    begin
                        rec_en        = 1'b1;
                        rec_st        = active_reg[id_slot] ||
                                        (!item_reg.cmd.rebase_now &&
                                         item_reg.cmd.interval == per_q) ?
                                        ST_DONE : ST_INACTIVE;
                        state_next    = S_SCAN;
                        mode_next     = M_WAIT;
                        scan_cnt_next = '0;
                        pv_next       = 1'b0;
                        got_next      = 1'b0;
                    end
                end
            end
            S_ARM:
            begin
                we_dl        = 1'b1;
                cand_dl_next = wdl;
                if (item_reg.cmd.operation == OP_ADD)
                begin
                    we_per = 1'b1;
                    we_rep = 1'b1;
                    active_next[cand_idx_reg] = 1'b1;
                end
                else if (item_reg.cmd.operation == OP_RESET)
                begin
                    we_per = 1'b1;
                end
                state_next    = S_SCAN;
                mode_next     = M_FIRST;
                scan_cnt_next = '0;
                pv_next       = 1'b0;
                first_next    = 1'b1;
            end
            S_REARM:
            begin
                wa  = best_reg;
                wdl = sat_add(now, best_per_reg);
                if (best_rep_reg)
                begin
                    we_dl = 1'b1;
                end
                else
                begin
                    active_next[best_reg] = 1'b0;
                end
                npick_next    = npick_reg + 1'b1;
                state_next    = S_SCAN;
                scan_cnt_next = '0;
                pv_next       = 1'b0;
                got_next      = 1'b0;
                if (npick_reg == 5'(MAX_OUT - 1))
                begin
                    mode_next = M_WAIT;
                    if (any_reg)
                    begin
                        last_seen_next = now;
                    end
                end
                else
                begin
                    mode_next = M_PICK;
                end
            end
            S_WAITEND:
            begin
                if (!got_reg)
                begin
                    w_next = TIME_MAX;
                end
                else
                begin
                    w_next = (now >= best_dl_reg) ? 48'd0 : best_dl_reg - now;
                end
                emit_next  = 4'd0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next            = 1'b1;
                    out_next.status           = rb_st[emit_reg];
                    out_next.timer_id_res     = rb_id[emit_reg];
                    out_next.earliest_changed = rb_ec[emit_reg];
                    out_next.next_wait        = w_reg;
                    out_next.last             = ({1'b0, emit_reg} == res_cnt_reg - 1'b1);
                    if ({1'b0, emit_reg} == res_cnt_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rec_en)
        begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_WAIT;
            active_reg    <= '0;
            picked_reg    <= '0;
            scan_cnt_reg  <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            got_reg       <= 1'b0;
            first_reg     <= 1'b1;
            any_reg       <= 1'b0;
            roll_reg      <= 1'b0;
            best_reg      <= '0;
            best_dl_reg   <= '0;
            best_per_reg  <= '0;
            best_rep_reg  <= 1'b0;
            cand_idx_reg  <= '0;
            cand_dl_reg   <= '0;
            arm_add_reg   <= '0;
            start_reg     <= '0;
            last_seen_reg <= '0;
            w_reg         <= '0;
            npick_reg     <= '0;
            res_cnt_reg   <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            active_reg    <= active_next;
            picked_reg    <= picked_next;
            scan_cnt_reg  <= scan_cnt_next;
            pv_reg        <= pv_next;
            pidx_reg      <= pidx_next;
            got_reg       <= got_next;
            first_reg     <= first_next;
            any_reg       <= any_next;
            roll_reg      <= roll_next;
            best_reg      <= best_next;
            best_dl_reg   <= best_dl_next;
            best_per_reg  <= best_per_next;
            best_rep_reg  <= best_rep_next;
            cand_idx_reg  <= cand_idx_next;
            cand_dl_reg   <= cand_dl_next;
            arm_add_reg   <= arm_add_next;
            start_reg     <= start_next;
            last_seen_reg <= last_seen_next;
            w_reg         <= w_next;
            npick_reg     <= npick_next;
            res_cnt_reg   <= res_cnt_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= 5'(MAX_OUT)) else $error("result buffer overrun");
    a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        npick_reg <= 5'(MAX_OUT)) else $error("too many expired beats");
    a_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result beat loaded outside emit");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_cnt_reg <= CW'(SLOTS)))
        else $error("scan counter out of range");
`endif

endmodule

/* rtl/core/deadline_timer_table.sv */
// ----------------------------------------------------------------------------
// deadline_timer_table
// Table of one-shot and cyclic deadline timers with ordered expiry.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue; a sequencer works one command at a time,
// scanning the timer memory one slot per cycle. Every command is fetched
// (IDLE) and decoded (DEC), then makes a final scan for the earliest deadline
// and forms the wait (WAITEND). add adds a free-slot scan and, when a slot is
// free, an arm step and an order scan; cancel adds nothing; reset and restart,
// when their slot check passes, read the slot (RD, EVAL) and, when they rearm,
// add an arm step and an order scan; an expire check adds one scan per due
// timer emitted plus a closing scan (none after the sixteenth) and one rearm
// step per timer. Results of a command then leave one beat per cycle while
// pop is high; the rollover window is written at byte address 0 of the
// register port.
module deadline_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [1:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    input  logic           push,
    output logic           full,
    input  dtt_pkg::cmd_t  cmd,
    output logic           empty,
    input  logic           pop,
    output dtt_pkg::res_t  res
);
    import dtt_pkg::*;

    logic [31:0] window_reg;
    logic        q_valid, q_pop;
    front_item_t q_item;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? window_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            window_reg <= pwdata;
        end
    end

    dtt_front #(.SLOTS(SLOTS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    dtt_back #(.SLOTS(SLOTS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .window  (window_reg),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

endmodule

/* verif/tb_deadline_timer_table.sv */
// ----------------------------------------------------------------------------
// tb_deadline_timer_table
// Drives timer commands through the command queue, predicts every result beat
// from a private copy of the timer table, and compares the beats field by
// field while both sides idle at random. The rollover window is rewritten
// between phases while the table is quiet.
// ----------------------------------------------------------------------------
module tb_deadline_timer_table;
    import dtt_pkg::*;

    localparam int          NSLOT     = 16;
    localparam logic [2:0]  OP_UNDEF_A = 3'd5;
    localparam logic [2:0]  OP_UNDEF_C = 3'd7;
    localparam logic [1:0]  ADDR_WINDOW = 2'd0;
    localparam int          DRAIN_CYCLES = 80;

    typedef struct {
        cmd_t       c;
        bit         typed;
        logic [2:0] st;
        logic [3:0] id;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push, full, empty, pop;
    cmd_t        cmd;
    res_t        res;

    // predictor copy of the timer table
    logic [47:0] tm_deadline [NSLOT];
    logic [31:0] tm_period   [NSLOT];
    bit          tm_active   [NSLOT];
    bit          tm_cyclic   [NSLOT];
    bit          tm_written  [NSLOT];
    logic [47:0] tm_last_seen;
    logic [31:0] tm_window;

    res_t        due_beats [$];
    row_t        rows [$];
    int          mismatches;
    logic [47:0] clock_ms;

    deadline_timer_table dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .cmd(cmd),
        .empty(empty), .pop(pop), .res(res)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [47:0] time_plus(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic bit ahead_of(input int a, input int b);
        if (tm_deadline[a] != tm_deadline[b])
            return tm_deadline[a] < tm_deadline[b];
        return a < b;
    endfunction

    function automatic bit leads(input int s);
        for (int j = 0; j < NSLOT; j++)
            if (j != s && tm_active[j] && ahead_of(j, s))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void note(input logic [2:0] st, input int id, input bit ec);
        res_t r;
        r = '0;
        r.status = st;
        r.timer_id_res = id[3:0];
        r.earliest_changed = ec;
        due_beats.insert(due_beats.size(), r);
    endfunction

    // apply one accepted command to the table copy, queue its result beats
    function automatic void predict_beats(input cmd_t c);
        int          first, n, s, b, cnt;
        bit          got, any, roll;
        bit          due [NSLOT];
        int          order [MAX_OUT];
        logic [47:0] start, best, wt;
        first = due_beats.size();
        case (c.operation)
            OP_ADD:
            begin
                s = -1;
                for (int j = NSLOT - 1; j >= 0; j--)
                    if (!tm_active[j])
                        s = j;
                if (s < 0)
                    note(ST_FULL, 0, 1'b0);
                else
                begin
                    tm_active[s] = 1'b1;
                    tm_written[s] = 1'b1;
                    tm_cyclic[s] = c.cyclic;
                    tm_period[s] = c.interval;
                    tm_deadline[s] = time_plus(c.now_ms, c.interval);
                    note(ST_DONE, s, leads(s));
                end
            end
            OP_CANCEL:
            begin
                if (tm_active[c.timer_id])
                begin
                    tm_active[c.timer_id] = 1'b0;
                    note(ST_DONE, c.timer_id, 1'b0);
                end
                else
                    note(ST_INACTIVE, c.timer_id, 1'b0);
            end
            OP_RESET:
            begin
                s = c.timer_id;
                if (!c.rebase_now && c.interval == tm_period[s])
                    note(ST_DONE, s, 1'b0);
                else if (!tm_active[s])
                    note(ST_INACTIVE, s, 1'b0);
                else
                begin
                    if (c.rebase_now)
                        start = c.now_ms;
                    else
                        start = tm_deadline[s] >= tm_period[s] ?
                                tm_deadline[s] - tm_period[s] : '0;
                    tm_period[s] = c.interval;
                    tm_deadline[s] = time_plus(start, c.interval);
                    note(ST_DONE, s, leads(s));
                end
            end
            OP_RESTART:
            begin
                s = c.timer_id;
                if (tm_active[s])
                begin
                    tm_deadline[s] = time_plus(c.now_ms, tm_period[s]);
                    note(ST_DONE, s, leads(s));
                end
                else
                    note(ST_INACTIVE, s, 1'b0);
            end
            OP_EXPIRE:
            begin
                any = 1'b0;
                for (int j = 0; j < NSLOT; j++)
                    any |= tm_active[j];
                if (!any)
                    note(ST_NONE_DUE, 0, 1'b0);
                else
                begin
                    roll = tm_last_seen >= {16'd0, tm_window} &&
                           c.now_ms < tm_last_seen - {16'd0, tm_window};
                    tm_last_seen = c.now_ms;
                    for (int j = 0; j < NSLOT; j++)
                        due[j] = tm_active[j] && (roll || tm_deadline[j] <= c.now_ms);
                    cnt = 0;
                    while (cnt < MAX_OUT)
                    begin
                        got = 1'b0;
                        b = 0;
                        for (int j = 0; j < NSLOT; j++)
                            if (due[j] && (!got || ahead_of(j, b)))
                            begin
                                b = j;
                                got = 1'b1;
                            end
                        if (!got)
                            break;
                        due[b] = 1'b0;
                        order[cnt] = b;
                        cnt++;
                    end
                    if (cnt == 0)
                        note(ST_NONE_DUE, 0, 1'b0);
                    // re-arm only after the whole order is fixed
                    for (int k = 0; k < cnt; k++)
                    begin
                        note(ST_EXPIRED, order[k], 1'b0);
                        if (tm_cyclic[order[k]])
                            tm_deadline[order[k]] = time_plus(c.now_ms, tm_period[order[k]]);
                        else
                            tm_active[order[k]] = 1'b0;
                    end
                end
            end
            default: note(ST_INACTIVE, 0, 1'b0);
        endcase
        any = 1'b0;
        best = '0;
        for (int j = 0; j < NSLOT; j++)
            if (tm_active[j] && (!any || tm_deadline[j] < best))
            begin
                best = tm_deadline[j];
                any = 1'b1;
            end
        wt = !any ? 48'hFFFF_FFFF_FFFF : (c.now_ms >= best ? 48'd0 : best - c.now_ms);
        n = due_beats.size();
        for (int k = first; k < n; k++)
            due_beats[k].next_wait = wt;
        due_beats[n - 1].last = 1'b1;
    endfunction

    function automatic cmd_t make_cmd(input logic [2:0] op, input logic [3:0] id,
                                      input logic [31:0] ivl, input bit cyc,
                                      input bit fn, input logic [47:0] now);
        cmd_t c;
        c.operation = op;
        c.timer_id = id;
        c.interval = ivl;
        c.cyclic = cyc;
        c.rebase_now = fn;
        c.now_ms = now;
        return c;
    endfunction

    function automatic void add_row(input cmd_t c, input bit typed,
                                    input logic [2:0] st, input logic [3:0] id);
        row_t r;
        r.c = c;
        r.typed = typed;
        r.st = st;
        r.id = id;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void flag_mismatch(input string what, input logic [47:0] want,
                                          input logic [47:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endfunction

    // random command aimed at the live part of the table
    function automatic cmd_t random_cmd();
        cmd_t        c;
        int          pick;
        logic [31:0] ivl;
        logic [3:0]  id;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0: clock_ms = 48'({$urandom, $urandom});
            1: clock_ms = clock_ms - $urandom_range(0, 8000000);
            default: clock_ms = clock_ms + $urandom_range(0, 3000);
        endcase
        case ($urandom_range(0, 9))
            0: ivl = $urandom;
            1: ivl = 32'hFFFF_FFFF;
            default: ivl = $urandom_range(0, 5000);
        endcase
        id = 4'($urandom_range(0, NSLOT - 1));
        c = make_cmd(OP_EXPIRE, id, ivl, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), clock_ms);
        if (pick < 30)
            c.operation = OP_ADD;
        else if (pick < 40)
            c.operation = OP_CANCEL;
        else if (pick < 55)
            c.operation = OP_RESET;
        else if (pick < 68)
            c.operation = OP_RESTART;
        else if (pick < 95)
            c.operation = OP_EXPIRE;
        else
            c.operation = 3'($urandom_range(OP_UNDEF_A, OP_UNDEF_C));
        // a reset of a slot that was never armed is never sent
        if (c.operation == OP_RESET && !tm_written[id])
            c.operation = OP_CANCEL;
        return c;
    endfunction

    int last_base;

    task automatic send_cmd(input cmd_t c);
        push <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (full);
        last_base = due_beats.size();
        predict_beats(c);
    endtask

    int burst_left;

    task automatic send_paced(input cmd_t c);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        burst_left--;
        send_cmd(c);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_WINDOW;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tm_window = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== v)
            flag_mismatch("window readback", v, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: check each beat, stall in changing patterns
    int stall_mode;
    int cyc_count;

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (due_beats.size() == 0)
                flag_mismatch("beat with nothing expected", 48'd0, {44'd0, res.timer_id_res});
            else
            begin
                res_t w;
                w = due_beats.pop_front();
                if (res.status !== w.status)
                    flag_mismatch("status", w.status, res.status);
                if (res.timer_id_res !== w.timer_id_res)
                    flag_mismatch("timer_id_res", w.timer_id_res, res.timer_id_res);
                if (res.next_wait !== w.next_wait)
                    flag_mismatch("next_wait", w.next_wait, res.next_wait);
                if (res.earliest_changed !== w.earliest_changed)
                    flag_mismatch("earliest_changed", w.earliest_changed, res.earliest_changed);
                if (res.last !== w.last)
                    flag_mismatch("last", w.last, res.last);
            end
        end
        cyc_count <= cyc_count + 1;
        if (cyc_count % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 3) == 0);
        endcase
    end

    logic [31:0] windows [4];

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        pop = 1'b0;
        cmd = '0;
        mismatches = 0;
        burst_left = 0;
        last_base = 0;
        stall_mode = 0;
        cyc_count = 0;
        for (int j = 0; j < NSLOT; j++)
        begin
            tm_deadline[j] = '0;
            tm_period[j] = '0;
            tm_active[j] = 1'b0;
            tm_cyclic[j] = 1'b0;
            tm_written[j] = 1'b0;
        end
        tm_last_seen = '0;
        tm_window = WINDOW_RESET;

        add_row(make_cmd(OP_EXPIRE, 4'd0, 32'd0, 0, 0, 48'd0), 1, ST_NONE_DUE, 4'd0);
        add_row(make_cmd(OP_CANCEL, 4'd3, 32'd0, 0, 0, 48'd10), 1, ST_INACTIVE, 4'd3);
        add_row(make_cmd(OP_RESTART, 4'd15, 32'd0, 0, 0, 48'd20), 1, ST_INACTIVE, 4'd15);
        add_row(make_cmd(OP_UNDEF_A, 4'd9, 32'd0, 1, 1, 48'd30), 1, ST_INACTIVE, 4'd0);
        add_row(make_cmd(OP_UNDEF_C, 4'd15, 32'hFFFF_FFFF, 1, 1, 48'd40), 1, ST_INACTIVE, 4'd0);
        add_row(make_cmd(OP_ADD, 4'd0, 32'd100, 0, 0, 48'd1000), 1, ST_DONE, 4'd0);
        add_row(make_cmd(OP_ADD, 4'd0, 32'hFFFF_FFFF, 1, 0, 48'd1000), 1, ST_DONE, 4'd1);
        add_row(make_cmd(OP_ADD, 4'd0, 32'd0, 1, 0, 48'd2000), 1, ST_DONE, 4'd2);
        add_row(make_cmd(OP_EXPIRE, 4'd0, 32'd0, 0, 0, 48'd2000), 0, 0, 0);
        add_row(make_cmd(OP_RESET, 4'd1, 32'd50, 0, 1, 48'd2000), 0, 0, 0);
        add_row(make_cmd(OP_RESET, 4'd1, 32'd500, 0, 0, 48'd2100), 0, 0, 0);
        // same period counted from the old start leaves the timer alone
        add_row(make_cmd(OP_RESET, 4'd1, 32'd500, 0, 0, 48'd2200), 0, 0, 0);
        add_row(make_cmd(OP_RESTART, 4'd1, 32'd0, 0, 0, 48'd3000), 0, 0, 0);
        add_row(make_cmd(OP_ADD, 4'd0, 32'hFFFF_FFFF, 0, 0, 48'hFFFF_FFFF_FF00), 0, 0, 0);
        // guard: last seen time below the window, so no rollover
        add_row(make_cmd(OP_EXPIRE, 4'd0, 32'd0, 0, 0, 48'd1500), 0, 0, 0);
        add_row(make_cmd(OP_EXPIRE, 4'd0, 32'd0, 0, 0, 48'hFFFF_FFFF_FFFF), 0, 0, 0);
        add_row(make_cmd(OP_ADD, 4'd0, 32'd900000, 0, 0, 48'd10), 0, 0, 0);
        // big backward step: rollover expires everything
        add_row(make_cmd(OP_EXPIRE, 4'd0, 32'd0, 0, 0, 48'd10), 0, 0, 0);
        for (int j = 0; j < NSLOT; j++)
            add_row(make_cmd(OP_ADD, 4'd0, 32'd7, 1'(j % 2), 0, 48'd100), 0, 0, 0);
        add_row(make_cmd(OP_ADD, 4'd0, 32'd7, 0, 0, 48'd100), 1, ST_FULL, 4'd0);
        add_row(make_cmd(OP_EXPIRE, 4'd0, 32'd0, 0, 0, 48'd107), 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_paced(rows[i].c);
            if (rows[i].typed)
            begin
                due_beats[last_base].status = rows[i].st;
                due_beats[last_base].timer_id_res = rows[i].id;
            end
        end
        settle();

        windows[0] = 32'd0;
        windows[1] = 32'd1000;
        windows[2] = 32'hFFFF_FFFF;
        windows[3] = $urandom;
        clock_ms = 48'd5000;
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
                write_window(windows[ph - 1]);
            for (int k = 0; k < 19; k++)
                send_paced(random_cmd());
            settle();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
